@@ src/wsf_pkg.sv @@
package wsf_pkg;

  localparam int unsigned PC_W = 7;
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0]  RST_FORMAT  = 2'd1;
  localparam logic [15:0] RST_CHANNEL = 16'd2;
  localparam logic [31:0] RST_RATE    = 32'd48000;
  localparam logic [31:0] RST_FRAMES  = 32'd0;

  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_CHANNEL = 2'd1;
  localparam logic [1:0] REG_RATE    = 2'd2;
  localparam logic [1:0] REG_FRAMES  = 2'd3;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  localparam logic       CMD_HEADER = 1'b0;

  localparam logic [PC_W-1:0] PC_HDR   = 7'd0;
  localparam logic [PC_W-1:0] PC_DTAG  = 7'd54;
  localparam logic [PC_W-1:0] PC_SMP   = 7'd62;
  localparam logic [PC_W-1:0] PC_PAD   = 7'd68;
  localparam logic [PC_W-1:0] PC_FBITS = 7'd69;

  typedef enum logic [2:0] {
    OP_EMIT,
    OP_MUL_ALIGN,
    OP_MUL_PERSEC,
    OP_MUL_FRAME,
    OP_RIFF,
    OP_MUL_SAMPLE,
    OP_SHIFT,
    OP_CONV
  } op_t;

  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_RIFF,
    SRC_FMTLEN,
    SRC_TAG,
    SRC_CC,
    SRC_RATE,
    SRC_PERSEC,
    SRC_ALIGN,
    SRC_NBITS,
    SRC_FRAME,
    SRC_NDATA,
    SRC_BITS,
    SRC_VAL
  } src_t;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOT_EXT,
    CND_NOT_FLOAT,
    CND_FLOAT,
    CND_FMT0,
    CND_FMT0_NOPAD,
    CND_FMT1,
    CND_NOPAD
  } cnd_t;

  typedef struct packed {
    op_t             op;
    src_t            src;
    logic [1:0]      bsel;
    logic [7:0]      cbyte;
    cnd_t            jcnd;
    logic [PC_W-1:0] jtgt;
    cnd_t            ecnd;
  } uword_t;

  function automatic uword_t u_op(op_t op, cnd_t jc, logic [PC_W-1:0] jt);
    uword_t u;
    u = '{op: op, src: SRC_CONST, bsel: 2'd0, cbyte: 8'd0, jcnd: jc, jtgt: jt,
          ecnd: CND_NEVER};
    return u;
  endfunction

  function automatic uword_t u_c(logic [7:0] c, cnd_t ec);
    uword_t u;
    u = '{op: OP_EMIT, src: SRC_CONST, bsel: 2'd0, cbyte: c, jcnd: CND_NEVER,
          jtgt: PC_HDR, ecnd: ec};
    return u;
  endfunction

  function automatic uword_t u_w(src_t s, logic [1:0] b, cnd_t jc, logic [PC_W-1:0] jt,
                                 cnd_t ec);
    uword_t u;
    u = '{op: OP_EMIT, src: s, bsel: b, cbyte: 8'd0, jcnd: jc, jtgt: jt, ecnd: ec};
    return u;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t u;
    case (pc)
      7'd0:  u = u_op(OP_MUL_ALIGN, CND_NEVER, PC_HDR);
      7'd1:  u = u_op(OP_MUL_PERSEC, CND_NEVER, PC_HDR);
      7'd2:  u = u_op(OP_MUL_FRAME, CND_NEVER, PC_HDR);
      7'd3:  u = u_op(OP_RIFF, CND_NEVER, PC_HDR);
      7'd4:  u = u_c(8'h52, CND_NEVER);
      7'd5:  u = u_c(8'h49, CND_NEVER);
      7'd6:  u = u_c(8'h46, CND_NEVER);
      7'd7:  u = u_c(8'h46, CND_NEVER);
      7'd8:  u = u_w(SRC_RIFF, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd9:  u = u_w(SRC_RIFF, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd10: u = u_w(SRC_RIFF, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd11: u = u_w(SRC_RIFF, 2'd3, CND_NEVER, PC_HDR, CND_NEVER);
      7'd12: u = u_c(8'h57, CND_NEVER);
      7'd13: u = u_c(8'h41, CND_NEVER);
      7'd14: u = u_c(8'h56, CND_NEVER);
      7'd15: u = u_c(8'h45, CND_NEVER);
      7'd16: u = u_c(8'h66, CND_NEVER);
      7'd17: u = u_c(8'h6d, CND_NEVER);
      7'd18: u = u_c(8'h74, CND_NEVER);
      7'd19: u = u_c(8'h20, CND_NEVER);
      7'd20: u = u_w(SRC_FMTLEN, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd21: u = u_w(SRC_FMTLEN, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd22: u = u_w(SRC_FMTLEN, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd23: u = u_w(SRC_FMTLEN, 2'd3, CND_NEVER, PC_HDR, CND_NEVER);
      7'd24: u = u_w(SRC_TAG, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd25: u = u_w(SRC_TAG, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd26: u = u_w(SRC_CC, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd27: u = u_w(SRC_CC, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd28: u = u_w(SRC_RATE, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd29: u = u_w(SRC_RATE, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd30: u = u_w(SRC_RATE, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd31: u = u_w(SRC_RATE, 2'd3, CND_NEVER, PC_HDR, CND_NEVER);
      7'd32: u = u_w(SRC_PERSEC, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd33: u = u_w(SRC_PERSEC, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd34: u = u_w(SRC_PERSEC, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd35: u = u_w(SRC_PERSEC, 2'd3, CND_NEVER, PC_HDR, CND_NEVER);
      7'd36: u = u_w(SRC_ALIGN, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd37: u = u_w(SRC_ALIGN, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd38: u = u_w(SRC_NBITS, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd39: u = u_w(SRC_NBITS, 2'd1, CND_NOT_EXT, PC_DTAG, CND_NEVER);
      7'd40: u = u_c(8'h00, CND_NEVER);
      7'd41: u = u_w(SRC_CONST, 2'd0, CND_NOT_FLOAT, PC_DTAG, CND_NEVER);
      7'd42: u = u_c(8'h66, CND_NEVER);
      7'd43: u = u_c(8'h61, CND_NEVER);
      7'd44: u = u_c(8'h63, CND_NEVER);
      7'd45: u = u_c(8'h74, CND_NEVER);
      7'd46: u = u_c(8'h04, CND_NEVER);
      7'd47: u = u_c(8'h00, CND_NEVER);
      7'd48: u = u_c(8'h00, CND_NEVER);
      7'd49: u = u_c(8'h00, CND_NEVER);
      7'd50: u = u_w(SRC_FRAME, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd51: u = u_w(SRC_FRAME, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd52: u = u_w(SRC_FRAME, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd53: u = u_w(SRC_FRAME, 2'd3, CND_NEVER, PC_HDR, CND_NEVER);
      7'd54: u = u_c(8'h64, CND_NEVER);
      7'd55: u = u_c(8'h61, CND_NEVER);
      7'd56: u = u_c(8'h74, CND_NEVER);
      7'd57: u = u_c(8'h61, CND_NEVER);
      7'd58: u = u_w(SRC_NDATA, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd59: u = u_w(SRC_NDATA, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd60: u = u_w(SRC_NDATA, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd61: u = u_w(SRC_NDATA, 2'd3, CND_NEVER, PC_HDR, CND_ALWAYS);
      7'd62: u = u_op(OP_MUL_SAMPLE, CND_FLOAT, PC_FBITS);
      7'd63: u = u_op(OP_SHIFT, CND_NEVER, PC_HDR);
      7'd64: u = u_op(OP_CONV, CND_NEVER, PC_HDR);
      7'd65: u = u_w(SRC_VAL, 2'd0, CND_FMT0, PC_PAD, CND_FMT0_NOPAD);
      7'd66: u = u_w(SRC_VAL, 2'd1, CND_NEVER, PC_HDR, CND_FMT1);
      7'd67: u = u_w(SRC_VAL, 2'd2, CND_NEVER, PC_HDR, CND_NOPAD);
      7'd68: u = u_c(8'h00, CND_ALWAYS);
      7'd69: u = u_w(SRC_BITS, 2'd0, CND_NEVER, PC_HDR, CND_NEVER);
      7'd70: u = u_w(SRC_BITS, 2'd1, CND_NEVER, PC_HDR, CND_NEVER);
      7'd71: u = u_w(SRC_BITS, 2'd2, CND_NEVER, PC_HDR, CND_NEVER);
      7'd72: u = u_w(SRC_BITS, 2'd3, CND_NEVER, PC_HDR, CND_ALWAYS);
      default: u = u_c(8'h00, CND_ALWAYS);
    endcase
    return u;
  endfunction

endpackage

@@ src/wsf_in_if.sv @@
interface wsf_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] sample_bits;
  logic        end_of_stream;

  modport source(output valid, cmd, sample_bits, end_of_stream, input ready);
  modport sink(input valid, cmd, sample_bits, end_of_stream, output ready);
endinterface

@@ src/wsf_out_if.sv @@
interface wsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, out_byte, last_of_run, input ready);
  modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

@@ src/wav_stream_formatter_top.sv @@
// Header command: 4 compute steps, then one byte per cycle while the output is
// not stalled (44, 46 or 58 bytes). Sample: 3 compute steps (multiply, align,
// saturate), then 1 to 3 bytes plus pad; float: 1 step, then 4 bytes.
// in_ready returns as the final byte is loaded, so no new item is taken while
// a run is in progress; the sequencer issues one step per cycle unless an emit
// step is held by a stalled output.
// rst_n is synchronous: sequencer idle, parity cleared, registers to defaults.
module wav_stream_formatter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  wsf_in_if.sink                          in_chan,
  wsf_out_if.source                       out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wsf_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [1:0]  fmt_r;
  logic [15:0] cc_r;
  logic [31:0] rate_r;
  logic [31:0] frames_r;

  logic                     busy_r;
  logic [wsf_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     parity_r;
  logic                     pad_r;
  logic [31:0]              bits_r;

  logic [17:0] align_r;
  logic [31:0] persec_r;
  logic [31:0] ndata_r;
  logic [31:0] riff_r;
  logic [47:0] prod_r;
  logic [24:0] ival_r;
  logic        sticky_r;
  logic [23:0] val_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  wsf_pkg::uword_t uw;
  logic            accept, out_free, advance, ended, do_jump;
  logic            is_float, is_ext;
  logic [31:0]     mul_a;
  logic [23:0]     mul_b;
  logic [55:0]     product;
  logic [31:0]     rnd;
  logic [31:0]     word;
  logic [7:0]      emit_byte;
  logic [7:0]      sh_full;
  logic [47:0]     shifted, lowmask;
  logic            s_bit;
  logic [7:0]      e_bits;
  logic            nan_in;
  logic signed [26:0] iv, t, maxv, minv;
  logic [23:0]     conv_val;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= wsf_pkg::RST_FORMAT;
      cc_r     <= wsf_pkg::RST_CHANNEL;
      rate_r   <= wsf_pkg::RST_RATE;
      frames_r <= wsf_pkg::RST_FRAMES;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wsf_pkg::REG_FORMAT:  fmt_r    <= pwdata[1:0];
        wsf_pkg::REG_CHANNEL: cc_r     <= pwdata[15:0];
        wsf_pkg::REG_RATE:    rate_r   <= pwdata;
        wsf_pkg::REG_FRAMES:  frames_r <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wsf_pkg::REG_FORMAT:  prdata = {30'd0, fmt_r};
      wsf_pkg::REG_CHANNEL: prdata = {16'd0, cc_r};
      wsf_pkg::REG_RATE:    prdata = rate_r;
      wsf_pkg::REG_FRAMES:  prdata = frames_r;
    endcase
  end

  assign is_float = (fmt_r == wsf_pkg::FMT_F32);
  assign is_ext   = (cc_r > 16'd2) || is_float;

  function automatic logic cond(wsf_pkg::cnd_t c, logic [1:0] fmt, logic flt, logic ext,
                                logic pad);
    logic r;
    case (c)
      wsf_pkg::CND_NEVER:      r = 1'b0;
      wsf_pkg::CND_ALWAYS:     r = 1'b1;
      wsf_pkg::CND_NOT_EXT:    r = !ext;
      wsf_pkg::CND_NOT_FLOAT:  r = !flt;
      wsf_pkg::CND_FLOAT:      r = flt;
      wsf_pkg::CND_FMT0:       r = (fmt == wsf_pkg::FMT_U8);
      wsf_pkg::CND_FMT0_NOPAD: r = (fmt == wsf_pkg::FMT_U8) && !pad;
      wsf_pkg::CND_FMT1:       r = (fmt == wsf_pkg::FMT_S16);
      wsf_pkg::CND_NOPAD:      r = !pad;
      default:                 r = 1'b0;
    endcase
    return r;
  endfunction

  // sequencer
  assign uw             = wsf_pkg::ucode(pc_r);
  assign in_chan.ready  = !busy_r;
  assign accept         = in_chan.valid && !busy_r;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign advance        = busy_r && ((uw.op != wsf_pkg::OP_EMIT) || out_free);
  assign ended          = advance && cond(uw.ecnd, fmt_r, is_float, is_ext, pad_r);
  assign do_jump        = cond(uw.jcnd, fmt_r, is_float, is_ext, pad_r);

  always_comb begin
    pc_nxt = pc_r;
    if (accept) begin
      pc_nxt = (in_chan.cmd == wsf_pkg::CMD_HEADER) ? wsf_pkg::PC_HDR : wsf_pkg::PC_SMP;
    end else if (advance) begin
      pc_nxt = do_jump ? uw.jtgt : pc_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pc_r     <= wsf_pkg::PC_HDR;
      parity_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (accept) begin
        busy_r <= 1'b1;
        if (in_chan.cmd == wsf_pkg::CMD_HEADER || in_chan.end_of_stream) begin
          parity_r <= 1'b0;
        end else begin
          parity_r <= !parity_r;
        end
      end else if (ended) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bits_r <= in_chan.sample_bits;
      pad_r  <= in_chan.end_of_stream && cc_r[0] && !parity_r &&
                (fmt_r == wsf_pkg::FMT_U8 || fmt_r == wsf_pkg::FMT_S24);
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = rate_r;
    mul_b = {6'd0, align_r};
    case (uw.op)
      wsf_pkg::OP_MUL_ALIGN: begin
        mul_a = {16'd0, cc_r};
        mul_b = {21'd0, {1'b0, fmt_r} + 3'd1};
      end
      wsf_pkg::OP_MUL_FRAME: mul_a = frames_r;
      wsf_pkg::OP_MUL_SAMPLE: begin
        mul_a = {8'd0, 1'b1, bits_r[22:0]};
        case (fmt_r)
          wsf_pkg::FMT_U8:  mul_b = 24'h0000ff;
          wsf_pkg::FMT_S16: mul_b = 24'h00ffff;
          default:          mul_b = 24'hffffff;
        endcase
      end
      default: ;
    endcase
  end

  assign product = {24'd0, mul_a} * {32'd0, mul_b};
  assign rnd     = (ndata_r + 32'd1) & 32'hffff_fffe;

  assign s_bit   = bits_r[31];
  assign e_bits  = bits_r[30:23];
  assign nan_in  = (e_bits == 8'hff) && (bits_r[22:0] != 23'd0);
  assign sh_full = 8'd150 - e_bits;
  assign shifted = prod_r >> sh_full[5:0];
  assign lowmask = (48'd1 << sh_full[5:0]) - 48'd1;

  always_comb begin
    iv = {2'b00, ival_r};
    unique case (fmt_r)
      wsf_pkg::FMT_U8: begin
        maxv = 27'sd255;
        minv = 27'sd0;
      end
      wsf_pkg::FMT_S16: begin
        maxv = 27'sd32767;
        minv = -27'sd32768;
      end
      default: begin
        maxv = 27'sd8388607;
        minv = -27'sd8388608;
      end
    endcase
    if (fmt_r == wsf_pkg::FMT_U8) begin
      if (!s_bit) begin
        t = (iv + 27'sd255) >>> 1;
      end else begin
        t = 27'sd255 - iv - $signed({26'd0, sticky_r});
        t = (t < 0) ? 27'sd0 : (t >>> 1);
      end
    end else begin
      if (!s_bit) begin
        t = (iv == 27'sd0) ? 27'sd0 : ((iv - 27'sd1) >>> 1);
      end else begin
        t = -((iv + 27'sd1) >>> 1);
      end
    end
    if (t > maxv) t = maxv;
    if (t < minv) t = minv;
    if (nan_in) t = 27'sd0;
    else if (e_bits >= 8'd128) t = s_bit ? minv : maxv;
    conv_val = t[23:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      case (uw.op)
        wsf_pkg::OP_MUL_ALIGN:  align_r  <= product[17:0];
        wsf_pkg::OP_MUL_PERSEC: persec_r <= product[31:0];
        wsf_pkg::OP_MUL_FRAME:  ndata_r  <= product[31:0];
        wsf_pkg::OP_RIFF: begin
          ndata_r <= rnd;
          riff_r  <= rnd + 32'd36 + (is_ext ? 32'd2 : 32'd0) + (is_float ? 32'd12 : 32'd0);
        end
        wsf_pkg::OP_MUL_SAMPLE: prod_r <= product[47:0];
        wsf_pkg::OP_SHIFT: begin
          if (e_bits < 8'd102) begin
            ival_r   <= 25'd0;
            sticky_r <= 1'b0;
          end else begin
            ival_r   <= shifted[24:0];
            sticky_r <= |(prod_r & lowmask);
          end
        end
        wsf_pkg::OP_CONV: val_r <= conv_val;
        default: ;
      endcase
    end
  end

  // byte select for emit steps
  always_comb begin
    case (uw.src)
      wsf_pkg::SRC_RIFF:   word = riff_r;
      wsf_pkg::SRC_FMTLEN: word = is_ext ? 32'd18 : 32'd16;
      wsf_pkg::SRC_TAG:    word = is_float ? 32'd3 : 32'd1;
      wsf_pkg::SRC_CC:     word = {16'd0, cc_r};
      wsf_pkg::SRC_RATE:   word = rate_r;
      wsf_pkg::SRC_PERSEC: word = persec_r;
      wsf_pkg::SRC_ALIGN:  word = {14'd0, align_r};
      wsf_pkg::SRC_NBITS:  word = {26'd0, {1'b0, fmt_r} + 3'd1, 3'd0};
      wsf_pkg::SRC_FRAME:  word = frames_r;
      wsf_pkg::SRC_NDATA:  word = ndata_r;
      wsf_pkg::SRC_BITS:   word = bits_r;
      wsf_pkg::SRC_VAL:    word = {8'd0, val_r};
      default:             word = {24'd0, uw.cbyte};
    endcase
    case (uw.bsel)
      2'd0:    emit_byte = word[7:0];
      2'd1:    emit_byte = word[15:8];
      2'd2:    emit_byte = word[23:16];
      default: emit_byte = word[31:24];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && uw.op == wsf_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && uw.op == wsf_pkg::OP_EMIT) begin
      out_byte_r <= emit_byte;
      out_last_r <= ended;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.last_of_run = out_last_r;

endmodule

@@ src/wsf_checker.sv @@
module wsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output transfer changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a run is in progress");

  a_ready_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid && out_last)
    else $error("input ready before final byte was loaded");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("non-final byte while sequencer idle");

endmodule

bind wav_stream_formatter_top wsf_checker u_wsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_last  (out_chan.last_of_run)
);

@@ dv/wav_stream_monitor.sv @@
module wav_stream_monitor
  import wsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  wsf_in_if                 in_mon,
  wsf_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                bytes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wav_octet_t;

  wav_octet_t wav_bytes[$];

  logic [1:0]  fmt_r;
  logic [15:0] chan_r;
  logic [31:0] rate_r;
  logic [31:0] frames_r;
  logic        parity_r;

  initial begin
    mismatch_count = 0;
    bytes_due = 0;
  end

  function automatic void put8(logic [7:0] d);
    wav_octet_t o;
    o.data = d;
    o.last = 1'b0;
    wav_bytes.push_back(o);
  endfunction

  function automatic void put16(logic [31:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v);
    put16(v >> 16);
  endfunction

  function automatic void put_tag(logic [31:0] t);
    put8(t[31:24]);
    put8(t[23:16]);
    put8(t[15:8]);
    put8(t[7:0]);
  endfunction

  // exact scaling of an IEEE single to PCM, truncated toward zero and saturated
  function automatic logic [31:0] pcm_code(logic [31:0] bits, logic [1:0] fmt);
    logic        s;
    logic [7:0]  e;
    logic [22:0] fr;
    logic [63:0] a, p, c, one, m;
    int          f;
    longint      maxv, minv, t;
    s  = bits[31];
    e  = bits[30:23];
    fr = bits[22:0];
    if (fmt == FMT_U8) begin
      a = 64'd255; maxv = 255; minv = 0;
    end else if (fmt == FMT_S16) begin
      a = 64'd65535; maxv = 32767; minv = -32768;
    end else begin
      a = 64'd16777215; maxv = 8388607; minv = -8388608;
    end
    if (e == 8'hff && fr != 23'd0) return 32'd0;
    if (e >= 8'd128) begin
      t = s ? minv : maxv;
      return t[31:0];
    end
    if (e < 8'd102) begin
      p = 64'd0;
      f = 48;
    end else begin
      p = a * {40'd0, 1'b1, fr};
      f = 150 - int'(e);
    end
    if (fmt == FMT_U8) begin
      c = 64'd255 << f;
      if (!s) m = p + c;
      else if (p >= c) return 32'd0;
      else m = c - p;
      t = longint'(m >> (f + 1));
    end else begin
      one = 64'd1 << f;
      if (!s) begin
        if (p < one) return 32'd0;
        t = longint'((p - one) >> (f + 1));
      end else begin
        t = -longint'((p + one) >> (f + 1));
      end
    end
    if (t > maxv) t = maxv;
    if (t < minv) t = minv;
    return t[31:0];
  endfunction

  function automatic void queue_header();
    logic [31:0] nbits, align, persec, ndata, hsize;
    logic        is_float, ext;
    nbits    = (32'(fmt_r) + 32'd1) * 32'd8;
    is_float = (fmt_r == FMT_F32);
    ext      = (chan_r > 16'd2) || is_float;
    align    = 32'(chan_r) * nbits / 32'd8;
    persec   = align * rate_r;
    ndata    = (frames_r * align + 32'd1) / 32'd2 * 32'd2;
    hsize    = 32'd44 + (ext ? 32'd2 : 32'd0) + (is_float ? 32'd12 : 32'd0);
    put_tag("RIFF");
    put32(hsize - 32'd8 + ndata);
    put_tag("WAVE");
    put_tag("fmt ");
    put32(ext ? 32'd18 : 32'd16);
    put16(is_float ? 32'd3 : 32'd1);
    put16(32'(chan_r));
    put32(rate_r);
    put32(persec);
    put16(align);
    put16(nbits);
    if (ext) put16(32'd0);
    if (is_float) begin
      put_tag("fact");
      put32(32'd4);
      put32(frames_r);
    end
    put_tag("data");
    put32(ndata);
    parity_r = 1'b0;
  endfunction

  function automatic void queue_sample(logic [31:0] bits, logic eos);
    logic [31:0] v;
    if (fmt_r == FMT_F32) begin
      put32(bits);
    end else begin
      v = pcm_code(bits, fmt_r);
      put8(v[7:0]);
      if (fmt_r != FMT_U8) put8(v[15:8]);
      if (fmt_r == FMT_S24) put8(v[23:16]);
    end
    parity_r = ~parity_r;
    if (eos) begin
      // odd-sized chunk gets a pad byte
      if ((fmt_r == FMT_U8 || fmt_r == FMT_S24) && chan_r[0] && parity_r) put8(8'h00);
      parity_r = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    wav_octet_t got, want;
    if (!rst_n) begin
      fmt_r    = RST_FORMAT;
      chan_r   = RST_CHANNEL;
      rate_r   = RST_RATE;
      frames_r = RST_FRAMES;
      parity_r = 1'b0;
      wav_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_FORMAT:  fmt_r    = pwdata[1:0];
          REG_CHANNEL: chan_r   = pwdata[15:0];
          REG_RATE:    rate_r   = pwdata;
          REG_FRAMES:  frames_r = pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_HEADER) queue_header();
        else queue_sample(in_mon.sample_bits, in_mon.end_of_stream);
        want = wav_bytes.pop_back();
        want.last = 1'b1;
        wav_bytes.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.data = out_mon.out_byte;
        got.last = out_mon.last_of_run;
        if (wav_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected byte %02h last %0b, nothing expected",
                   $time, got.data, got.last);
        end else begin
          want = wav_bytes.pop_front();
          if (got.data !== want.data || got.last !== want.last) begin
            mismatch_count++;
            $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want.data, want.last, got.data, got.last);
          end
        end
      end
    end
    bytes_due = wav_bytes.size();
  end

endmodule

@@ dv/tb_wav_stream_formatter_top.sv @@
module tb_wav_stream_formatter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsf_pkg::*;

  localparam logic CMD_SAMPLE  = ~CMD_HEADER;
  localparam int   CYCLE_LIMIT = 1000000;
  localparam int   PASS_ITEMS  = 105;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatch_count;
  int                bytes_due;
  int                send_idle_pct;
  int                stall_pct;
  int                items_sent;
  int                cycles;

  wsf_in_if  in_if();
  wsf_out_if out_if();

  wav_stream_formatter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wav_stream_monitor monitor_u (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .bytes_due     (bytes_due)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(input logic cmd, input logic [31:0] bits, input logic eos);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid         <= 1'b0;
      in_if.cmd           <= 1'($urandom_range(0, 1));
      in_if.sample_bits   <= $urandom;
      in_if.end_of_stream <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= cmd;
    in_if.sample_bits   <= bits;
    in_if.end_of_stream <= eos;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
  endtask

  // hold the sender until every queued byte has been transferred
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic [15:0] chan,
                            input logic [31:0] rate, input logic [31:0] frames);
    drain();
    cfg_write(REG_FORMAT, {30'd0, fmt});
    cfg_write(REG_CHANNEL, {16'd0, chan});
    cfg_write(REG_RATE, rate);
    cfg_write(REG_FRAMES, frames);
  endtask

  function automatic logic [31:0] rand_sample();
    int         sel;
    logic [7:0] e;
    sel = $urandom_range(0, 99);
    if (sel < 55) e = 8'($urandom_range(100, 126));
    else if (sel < 65) e = 8'($urandom_range(101, 103));
    else if (sel < 73) return {1'($urandom_range(0, 1)), 8'd127, 23'd0};
    else if (sel < 78) e = 8'd127;
    else if (sel < 84) e = 8'($urandom_range(128, 255));
    else if (sel < 90) e = 8'($urandom_range(0, 101));
    else return $urandom;
    return {1'($urandom_range(0, 1)), e, 23'($urandom)};
  endfunction

  task automatic random_segment();
    int          n;
    logic [1:0]  fmt;
    logic [15:0] chan;
    logic [31:0] rate, frames;
    logic        eos;
    fmt = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: chan = 16'd1;
      1: chan = 16'd2;
      2: chan = 16'd3;
      3: chan = 16'hffff;
      4: chan = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      default: chan = 16'($urandom_range(1, 9));
    endcase
    case ($urandom_range(0, 3))
      0: rate = 32'd1;
      1: rate = 32'hffff_ffff;
      2: rate = 32'd48000;
      default: rate = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: frames = 32'd0;
      1: frames = 32'hffff_ffff;
      2: frames = $urandom_range(1, 1000);
      default: frames = $urandom;
    endcase
    set_config(fmt, chan, rate, frames);
    n = $urandom_range(1, 10);
    if ($urandom_range(0, 5) != 0) send_item(CMD_HEADER, $urandom, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) eos = ($urandom_range(0, 4) != 0);
      else eos = ($urandom_range(0, 19) == 0);
      if (i == n / 2 && $urandom_range(0, 7) == 0) drain();
      send_item(CMD_SAMPLE, rand_sample(), eos);
    end
  endtask

  initial begin
    int pass_start;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_HEADER;
    in_if.sample_bits   = '0;
    in_if.end_of_stream = 1'b0;
    out_if.ready        = 1'b0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    items_sent          = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // defaults from reset, sample ahead of any header
    send_item(CMD_SAMPLE, 32'h3f00_0000, 1'b0);
    send_item(CMD_HEADER, 32'h0, 1'b0);
    send_item(CMD_SAMPLE, 32'h3f80_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'hbf80_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'h0000_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'h7fc0_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'h7f80_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'hff80_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'h3280_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'h3300_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'h8000_0000, 1'b1);

    // 8-bit, odd channel count, odd sample count: pad byte
    set_config(FMT_U8, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_HEADER, 32'hffff_ffff, 1'b1);
    send_item(CMD_SAMPLE, 32'hbf80_0000, 1'b0);
    send_item(CMD_SAMPLE, 32'hffff_ffff, 1'b0);
    send_item(CMD_SAMPLE, 32'h3eff_ffff, 1'b1);

    set_config(FMT_S24, 16'd1, 32'd1, 32'd1);
    send_item(CMD_HEADER, 32'h0, 1'b0);
    send_item(CMD_SAMPLE, 32'h3f80_0000, 1'b1);
    send_item(CMD_SAMPLE, 32'h4b00_0000, 1'b0);

    // float with zero channels
    set_config(FMT_F32, 16'd0, 32'd44100, 32'd12345);
    send_item(CMD_HEADER, 32'h0, 1'b0);
    send_item(CMD_SAMPLE, 32'hdead_beef, 1'b0);
    send_item(CMD_SAMPLE, 32'h7fc0_0001, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      pass_start = items_sent;
      while (items_sent < pass_start + PASS_ITEMS) random_segment();
    end

    drain();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
